[sv/srt_pkg.sv]
// Shared types and constants for the sorted range table floor lookup core.
// Holds table geometry, command and status codes, and inter-module structs.
// No dependencies.
`default_nettype none

package srt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 32;
    localparam int REGION_W   = 10;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 80;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_RESP
    } ctrl_state_t;

    // table memory access from the controller
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [ADDR_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    // one finished result
    typedef struct packed {
        logic                found;
        logic [REGION_W-1:0] region_index;
        logic [ADDR_W-1:0]   range_low;
        logic [ADDR_W-1:0]   range_high;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

[sv/srt_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// Standalone; no package dependency.
`default_nettype none

module srt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/srt_ctrl.sv]
// Command sequencer: table bookkeeping, appends and the binary search.
// Depends on srt_pkg; drives the table memory through a ram_req_t.
`default_nettype none

module srt_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [srt_pkg::CMD_W-1:0]    in_cmd,
    input  wire logic [srt_pkg::ADDR_W-1:0]   in_addr,
    output srt_pkg::ram_req_t                 ram_req,
    input  wire logic [srt_pkg::ADDR_W-1:0]   ram_rdata,
    output logic                              res_valid,
    input  wire logic                         res_free,
    output srt_pkg::result_t                  res
);

    import srt_pkg::*;

    // upper middle of [lo, hi]
    function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
        logic [CNT_W-1:0] span;
        span = CNT_W'(hi) - CNT_W'(lo) + CNT_W'(1);
        return lo + IDX_W'(span >> 1);
    endfunction

    ctrl_state_t         state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [ADDR_W-1:0]   first_reg,  first_next;
    logic [ADDR_W-1:0]   last_reg,   last_next;
    logic [ADDR_W-1:0]   addr_reg,   addr_next;
    logic [IDX_W-1:0]    lo_reg,     lo_next;
    logic [IDX_W-1:0]    hi_reg,     hi_next;
    logic [IDX_W-1:0]    mid_reg,    mid_next;
    logic                found_reg,  found_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic             accept;
    logic             table_full;
    logic [IDX_W-1:0] step_lo;
    logic [IDX_W-1:0] step_hi;
    logic [IDX_W-1:0] init_hi;

    assign accept     = in_valid && in_ready;
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign init_hi    = IDX_W'(count_reg - CNT_W'(1));

    // narrow the search window from the entry just read
    always_comb begin
        if (ram_rdata <= addr_reg) begin
            step_lo = mid_reg;
            step_hi = hi_reg;
        end else begin
            step_lo = lo_reg;
            step_hi = mid_reg - IDX_W'(1);
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        first_reg  <= first_next;
        last_reg   <= last_next;
        addr_reg   <= addr_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    // next state and outputs
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        addr_next   = addr_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        found_next  = found_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_req     = '0;

        case (state_reg)
            ST_IDLE: begin
                // no item is taken while reset is held
                in_ready = aresetn;
                if (accept) begin
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    lo_next     = '0;
                    addr_next   = in_addr;
                    state_next  = ST_RESP;
                    if (in_cmd == CMD_CLEAR) begin
                        count_next = '0;
                    end else if (in_cmd == CMD_APPEND) begin
                        if (table_full) begin
                            status_next = STAT_FULL;
                        end else if (count_reg != '0 && in_addr <= last_reg) begin
                            status_next = STAT_ORDER;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = IDX_W'(count_reg);
                            ram_req.wdata = in_addr;
                            if (count_reg == '0) begin
                                first_next = in_addr;
                            end
                            last_next  = in_addr;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (in_cmd == CMD_LOOKUP) begin
                        if (count_reg != '0 && first_reg <= in_addr) begin
                            found_next = 1'b1;
                            hi_next    = init_hi;
                            if (init_hi != '0) begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = mid_of('0, init_hi);
                                mid_next      = mid_of('0, init_hi);
                                state_next    = ST_STEP;
                            end
                        end
                    end
                end
            end
            ST_STEP: begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = mid_of(step_lo, step_hi);
                    mid_next      = mid_of(step_lo, step_hi);
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result fields from the table state after the item
    always_comb begin
        res.found        = found_reg;
        res.region_index = REGION_W'(lo_reg);
        res.range_low    = (count_reg != '0) ? first_reg : '0;
        res.range_high   = (count_reg != '0) ? last_reg  : '0;
        res.status       = status_reg;
    end

    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // every search step has a nonempty window with mid inside it
    a_step_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> (lo_reg < hi_reg && mid_reg > lo_reg && mid_reg <= hi_reg))
        else $error("search window malformed");

    // each step consumes a read issued in the previous cycle
    a_step_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> $past(ram_req.re))
        else $error("search step without a table read");

    // a valid append grows the table by one
    a_append_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_cmd == CMD_APPEND && !table_full
         && (count_reg == '0 || in_addr > last_reg))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the table");

    // a found result needs a nonempty table
    a_found_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && found_reg) |-> count_reg != '0)
        else $error("found reported on empty table");

endmodule

`default_nettype wire

[sv/sorted_range_table_floor_lookup_core.sv]
// Top level of the sorted range table floor lookup core.
// Instantiates srt_ctrl and srt_ram, holds the output register; uses srt_pkg.
//
//  channel | direction | ports                          | contents
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser | command, address
//  m_      | out       | m_tvalid m_tready m_tdata      | found, index, range, status
//
// Clear, append, unused and missing lookup items go from idle straight to the
// response state; a lookup that finds an entry in a table of two or more entries
// first runs a binary search, one table memory read per step on the single read port.
// Reset clears the entry count; the table memory itself is not cleared.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module sorted_range_table_floor_lookup_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [31:0] address
    input  wire logic [srt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  wire logic [srt_pkg::CMD_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] found, [10:1] region_index, [42:11] range_low,
    // [74:43] range_high, [76:75] status, [79:77] zero
    output logic [srt_pkg::M_TDATA_W-1:0]       m_tdata
);

    import srt_pkg::*;

    ram_req_t          ram_req;
    logic [ADDR_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_free;
    result_t           res;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    srt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_addr   (s_tdata),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_free  (res_free),
        .res       (res)
    );

    srt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // output register takes a result when empty or draining
    assign res_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, res.status, res.range_high, res.range_low,
                             res.region_index, res.found};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
